// File: rtl/core/sgi_pkg.sv
// ----------------------------------------------------------------------------
// sgi_pkg
// Types and constants shared by the segment intersection block and its
// channel interfaces.
// ----------------------------------------------------------------------------
package sgi_pkg;

  localparam int CoordW = 32;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int SumW   = ProdW + 1;
  localparam int MagW   = ProdW;
  localparam int QuotW  = CoordW;
  localparam int ZSumW  = CoordW + 2;

  typedef struct packed {
    logic signed [CoordW-1:0] p0_x;
    logic signed [CoordW-1:0] p0_y;
    logic signed [CoordW-1:0] p0_z;
    logic signed [CoordW-1:0] p1_x;
    logic signed [CoordW-1:0] p1_y;
    logic signed [CoordW-1:0] p1_z;
    logic signed [CoordW-1:0] q0_x;
    logic signed [CoordW-1:0] q0_y;
    logic signed [CoordW-1:0] q0_z;
    logic signed [CoordW-1:0] q1_x;
    logic signed [CoordW-1:0] q1_y;
    logic signed [CoordW-1:0] q1_z;
  } seg_pair_t;

  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] cross_x;
    logic signed [CoordW-1:0] cross_y;
    logic signed [CoordW-1:0] cross_z;
  } cross_t;

endpackage

// File: rtl/core/sgi_in_if.sv
// ----------------------------------------------------------------------------
// sgi_in_if
// Input channel: one beat carries two segments.
// ----------------------------------------------------------------------------
interface sgi_in_if;
  logic              valid;
  logic              ready;
  sgi_pkg::seg_pair_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/sgi_out_if.sv
// ----------------------------------------------------------------------------
// sgi_out_if
// Output channel: one beat carries the hit flag and the crossing point.
// ----------------------------------------------------------------------------
interface sgi_out_if;
  logic           valid;
  logic           ready;
  sgi_pkg::cross_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/segment_intersection_2d.sv
// A beat passes stages 1 to 6, the divider stages and the output register.
// Throughput: one beat per cycle; the whole pipeline holds while the output
// is stalled. The depth is set by two 32-stage restoring dividers, one
// quotient bit per stage, that form the x and y offsets.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// segment_intersection_2d
// XY intersection of two segments in Q16.16 with an exact hit test and a
// truncated crossing point, plus the floor mean of the four z values.
// ----------------------------------------------------------------------------
module segment_intersection_2d (
  input  logic   clk,
  input  logic   rst,
  sgi_in_if.sink   in,
  sgi_out_if.source out
);

  localparam int CW = sgi_pkg::CoordW;
  localparam int DW = sgi_pkg::DiffW;
  localparam int PW = sgi_pkg::ProdW;
  localparam int SW = sgi_pkg::SumW;
  localparam int MW = sgi_pkg::MagW;
  localparam int QW = sgi_pkg::QuotW;
  localparam int HW = MW - DW;
  localparam int LoW = DW + CW;
  localparam int HiW = HW + CW;
  localparam int FullW = MW + CW;

  typedef struct packed {
    logic signed [DW-1:0] dpx, dpy, dqx, dqy, ex, ey;
    logic signed [CW-1:0] p0x, p0y, zm;
  } s1_t;

  typedef struct packed {
    logic signed [PW-1:0] dqx_ey, dqy_ex, dpx_ey, dpy_ex, dqy_dpx, dqx_dpy;
    logic signed [DW-1:0] dpx, dpy;
    logic signed [CW-1:0] p0x, p0y, zm;
  } s2_t;

  typedef struct packed {
    logic signed [SW-1:0] ua, ub, den;
    logic signed [DW-1:0] dpx, dpy;
    logic signed [CW-1:0] p0x, p0y, zm;
  } s3_t;

  typedef struct packed {
    logic          hit;
    logic [MW-1:0] nm, dm;
    logic [CW-1:0] mx, my;
    logic          sx, sy;
    logic signed [CW-1:0] p0x, p0y, zm;
  } s4_t;

  typedef struct packed {
    logic           hit;
    logic [LoW-1:0] lox, loy;
    logic [HiW-1:0] hix, hiy;
    logic [MW-1:0]  dm;
    logic           sx, sy;
    logic signed [CW-1:0] p0x, p0y, zm;
  } s5_t;

  typedef struct packed {
    logic          hit;
    logic [MW-1:0] rx, ry;
    logic [QW-1:0] lowx, lowy;
    logic [QW-1:0] qx, qy;
    logic [MW-1:0] dm;
    logic          sx, sy;
    logic signed [CW-1:0] p0x, p0y, zm;
  } dv_t;

  logic en;
  logic v1, v2, v3, v4, v5;
  logic [QW:0] vd;
  s1_t s1;
  s2_t s2;
  s3_t s3;
  s4_t s4;
  s5_t s5;
  dv_t dv [QW+1];
  sgi_pkg::cross_t res;
  logic res_valid;

  assign en       = !res_valid || out.ready;
  assign in.ready = en;

  // Stage 1: exact 33-bit differences and the floor mean of z.
  logic signed [sgi_pkg::ZSumW-1:0] zsum;
  always_comb begin
    zsum = sgi_pkg::ZSumW'(in.data.p0_z) + sgi_pkg::ZSumW'(in.data.p1_z)
         + sgi_pkg::ZSumW'(in.data.q0_z) + sgi_pkg::ZSumW'(in.data.q1_z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.dpx <= DW'(in.data.p1_x) - DW'(in.data.p0_x);
      s1.dpy <= DW'(in.data.p1_y) - DW'(in.data.p0_y);
      s1.dqx <= DW'(in.data.q1_x) - DW'(in.data.q0_x);
      s1.dqy <= DW'(in.data.q1_y) - DW'(in.data.q0_y);
      s1.ex  <= DW'(in.data.p0_x) - DW'(in.data.q0_x);
      s1.ey  <= DW'(in.data.p0_y) - DW'(in.data.q0_y);
      s1.p0x <= in.data.p0_x;
      s1.p0y <= in.data.p0_y;
      s1.zm  <= CW'(zsum >>> 2);
    end
  end

  // Stage 2: the six cross products.
  always_ff @(posedge clk) begin
    if (en) begin
      s2.dqx_ey  <= PW'(s1.dqx) * PW'(s1.ey);
      s2.dqy_ex  <= PW'(s1.dqy) * PW'(s1.ex);
      s2.dpx_ey  <= PW'(s1.dpx) * PW'(s1.ey);
      s2.dpy_ex  <= PW'(s1.dpy) * PW'(s1.ex);
      s2.dqy_dpx <= PW'(s1.dqy) * PW'(s1.dpx);
      s2.dqx_dpy <= PW'(s1.dqx) * PW'(s1.dpy);
      s2.dpx <= s1.dpx;
      s2.dpy <= s1.dpy;
      s2.p0x <= s1.p0x;
      s2.p0y <= s1.p0y;
      s2.zm  <= s1.zm;
    end
  end

  // Stage 3: numerators and denominator.
  always_ff @(posedge clk) begin
    if (en) begin
      s3.ua  <= SW'(s2.dqx_ey) - SW'(s2.dqy_ex);
      s3.ub  <= SW'(s2.dpx_ey) - SW'(s2.dpy_ex);
      s3.den <= SW'(s2.dqy_dpx) - SW'(s2.dqx_dpy);
      s3.dpx <= s2.dpx;
      s3.dpy <= s2.dpy;
      s3.p0x <= s2.p0x;
      s3.p0y <= s2.p0y;
      s3.zm  <= s2.zm;
    end
  end

  // Stage 4: hit test by signs and magnitudes, no division.
  logic [SW-1:0] mag_ua, mag_ub, mag_den;
  logic [DW-1:0] mag_dpx, mag_dpy;
  logic in_a, in_b, hit4;
  always_comb begin
    mag_ua  = s3.ua[SW-1]  ? SW'(-s3.ua)  : SW'(s3.ua);
    mag_ub  = s3.ub[SW-1]  ? SW'(-s3.ub)  : SW'(s3.ub);
    mag_den = s3.den[SW-1] ? SW'(-s3.den) : SW'(s3.den);
    mag_dpx = s3.dpx[DW-1] ? DW'(-s3.dpx) : DW'(s3.dpx);
    mag_dpy = s3.dpy[DW-1] ? DW'(-s3.dpy) : DW'(s3.dpy);
    in_a = ((s3.ua == '0) || (s3.ua[SW-1] == s3.den[SW-1])) && (mag_ua <= mag_den);
    in_b = ((s3.ub == '0) || (s3.ub[SW-1] == s3.den[SW-1])) && (mag_ub <= mag_den);
    hit4 = (s3.den != '0) && in_a && in_b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4.hit <= hit4;
      s4.nm  <= mag_ua[MW-1:0];
      s4.dm  <= mag_den[MW-1:0];
      s4.mx  <= mag_dpx[CW-1:0];
      s4.my  <= mag_dpy[CW-1:0];
      s4.sx  <= s3.dpx[DW-1];
      s4.sy  <= s3.dpy[DW-1];
      s4.p0x <= s3.p0x;
      s4.p0y <= s3.p0y;
      s4.zm  <= s3.zm;
    end
  end

  // Stage 5: |ua| * |delta| as two partial products per axis.
  always_ff @(posedge clk) begin
    if (en) begin
      s5.lox <= LoW'(s4.nm[DW-1:0]) * LoW'(s4.mx);
      s5.loy <= LoW'(s4.nm[DW-1:0]) * LoW'(s4.my);
      s5.hix <= HiW'(s4.nm[MW-1:DW]) * HiW'(s4.mx);
      s5.hiy <= HiW'(s4.nm[MW-1:DW]) * HiW'(s4.my);
      s5.hit <= s4.hit;
      s5.dm  <= s4.dm;
      s5.sx  <= s4.sx;
      s5.sy  <= s4.sy;
      s5.p0x <= s4.p0x;
      s5.p0y <= s4.p0y;
      s5.zm  <= s4.zm;
    end
  end

  // Stage 6: full dividends. The quotient fits in 32 bits, so the upper
  // dividend bits already form the partial remainder.
  logic [FullW-1:0] prod_x, prod_y;
  always_comb begin
    prod_x = FullW'(s5.lox) + (FullW'(s5.hix) << DW);
    prod_y = FullW'(s5.loy) + (FullW'(s5.hiy) << DW);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].hit  <= s5.hit;
      dv[0].rx   <= prod_x[FullW-1:QW];
      dv[0].ry   <= prod_y[FullW-1:QW];
      dv[0].lowx <= prod_x[QW-1:0];
      dv[0].lowy <= prod_y[QW-1:0];
      dv[0].qx   <= '0;
      dv[0].qy   <= '0;
      dv[0].dm   <= s5.dm;
      dv[0].sx   <= s5.sx;
      dv[0].sy   <= s5.sy;
      dv[0].p0x  <= s5.p0x;
      dv[0].p0y  <= s5.p0y;
      dv[0].zm   <= s5.zm;
    end
  end

  // Restoring division, one quotient bit per stage for each axis.
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [MW:0] tx, ty;
    logic        gx, gy;
    always_comb begin
      tx = {dv[k].rx, dv[k].lowx[QW-1]};
      ty = {dv[k].ry, dv[k].lowy[QW-1]};
      gx = tx >= {1'b0, dv[k].dm};
      gy = ty >= {1'b0, dv[k].dm};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1].rx   <= gx ? MW'(tx - {1'b0, dv[k].dm}) : MW'(tx);
        dv[k+1].ry   <= gy ? MW'(ty - {1'b0, dv[k].dm}) : MW'(ty);
        dv[k+1].lowx <= {dv[k].lowx[QW-2:0], 1'b0};
        dv[k+1].lowy <= {dv[k].lowy[QW-2:0], 1'b0};
        dv[k+1].qx   <= {dv[k].qx[QW-2:0], gx};
        dv[k+1].qy   <= {dv[k].qy[QW-2:0], gy};
        dv[k+1].hit  <= dv[k].hit;
        dv[k+1].dm   <= dv[k].dm;
        dv[k+1].sx   <= dv[k].sx;
        dv[k+1].sy   <= dv[k].sy;
        dv[k+1].p0x  <= dv[k].p0x;
        dv[k+1].p0y  <= dv[k].p0y;
        dv[k+1].zm   <= dv[k].zm;
      end
    end
  end

  // Output register: apply the offset sign and clear fields on a miss.
  logic [CW-1:0] off_x, off_y;
  always_comb begin
    off_x = dv[QW].sx ? CW'(-dv[QW].qx) : dv[QW].qx;
    off_y = dv[QW].sy ? CW'(-dv[QW].qy) : dv[QW].qy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.hit     <= dv[QW].hit;
      res.cross_x <= dv[QW].hit ? CW'(dv[QW].p0x + off_x) : '0;
      res.cross_y <= dv[QW].hit ? CW'(dv[QW].p0y + off_y) : '0;
      res.cross_z <= dv[QW].hit ? dv[QW].zm : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      vd <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      v1 <= in.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      vd <= {vd[QW-1:0], v5};
      res_valid <= vd[QW];
    end
  end

  assign out.valid = res_valid;
  assign out.data  = res;

  // A miss always carries an all-zero point.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.data.hit) |->
      (out.data.cross_x == '0 && out.data.cross_y == '0 && out.data.cross_z == '0))
    else $error("miss beat with nonzero point");

  // A zero denominator never reaches the divider as a hit.
  a_den_zero: assert property (@(posedge clk) disable iff (rst)
    (en && v4) |=> !(v5 && s5.hit && s5.dm == '0))
    else $error("hit with zero denominator");

  // A stalled result keeps the pipeline frozen.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out.ready) |=> (res_valid && $stable(vd) && $stable(res)))
    else $error("pipeline moved under a stalled result");

endmodule
